>>> hdl/pirb_pkg.sv
`default_nettype none

package pirb_pkg;

    // Field widths of one input item
    localparam int OFF_W     = 24;
    localparam int ROT_W     = 18;
    localparam int AXES      = 3;
    localparam int IN_DATA_W = 240;
    localparam int OUT_DATA_W = 8;

    // Box geometry and arithmetic widths
    localparam int SIZE_W = 24;
    localparam int PROD_W = OFF_W + ROT_W;
    localparam int SUM_W  = PROD_W + 2;
    localparam int MAG_W  = PROD_W;
    localparam int LIM_W  = SIZE_W + 1;
    localparam int SQ_W   = 2 * SIZE_W;

    // Configuration register map
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_HALF_SIZE_X = 2'd0,
        REG_HALF_SIZE_Y = 2'd1,
        REG_HALF_SIZE_Z = 2'd2,
        REG_GROW_RADIUS = 2'd3
    } cfg_reg_t;

    // Reset values of the geometry registers
    localparam logic [SIZE_W-1:0] RESET_HALF_SIZE = 24'd32768;
    localparam logic [SIZE_W-1:0] RESET_RADIUS    = 24'd32768;
    localparam logic [SQ_W-1:0]   RESET_RADIUS_SQ = 48'd1073741824;

endpackage

`default_nettype wire

>>> hdl/point_in_rounded_box_core.sv
// Point test against a box grown by a sphere (rounded edges and corners).
//
// Input stream (s_axis_*): one transaction carries the point offset from the
// box centre and the box rotation. Output stream (m_axis_*): one transaction
// per input, bit 0 set when the point lies inside the grown box.
// Configuration channel (cfg_*): writes half sizes and grow radius by index;
// write only while the pipeline is empty. cfg_ready is always high.
//
// Pipeline: six register stages (products, sums, magnitudes, axis distances,
// squares, result). Throughput: one item per cycle while m_axis_tready does
// not stall the output, set by the nine parallel product multipliers feeding
// the fully registered stages.
// Every stage has its own valid bit and loads whenever it is empty or its
// successor moves, so bubbles close up even while the output is stalled.
// A stall on m_axis_tready holds the result and the items behind it; nothing
// is dropped or repeated. s_axis_tready falls only when all stages are full.
//
// Reset (rst_n low, asynchronous) empties the pipeline and sets all half
// sizes and the radius to 0.5 in the fixed-point format.
`default_nettype none

module point_in_rounded_box_core #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // s_axis_tdata, from bit 0 up: offset_x, offset_y, offset_z (24 b each),
    // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22
    // (18 b each), zero fill to 240 b
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [pirb_pkg::IN_DATA_W-1:0]      s_axis_tdata,
    // m_axis_tdata, from bit 0 up: inside_res (1 b), zero fill to 8 b
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic [pirb_pkg::OUT_DATA_W-1:0]          m_axis_tdata,
    // Configuration write channel
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pirb_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [pirb_pkg::SIZE_W-1:0]         cfg_data
);

    localparam int STAGES = 6;
    localparam int AW     = pirb_pkg::MAG_W - FRAC_BITS;
    localparam int CW     = (AW > pirb_pkg::LIM_W) ? AW : pirb_pkg::LIM_W;

    // Configuration registers
    logic [pirb_pkg::SIZE_W-1:0] half_size_reg [pirb_pkg::AXES];
    logic [pirb_pkg::SIZE_W-1:0] grow_radius_reg;
    logic [pirb_pkg::SQ_W-1:0]   radius_sq_reg;

    // Pipeline control
    logic [STAGES:1] valid_reg;
    logic [STAGES:1] stage_en;

    // Stage payloads
    logic signed [pirb_pkg::OFF_W-1:0]  off_in [pirb_pkg::AXES];
    logic signed [pirb_pkg::ROT_W-1:0]  rot_in [pirb_pkg::AXES][pirb_pkg::AXES];
    logic signed [pirb_pkg::PROD_W-1:0] prod_next [pirb_pkg::AXES][pirb_pkg::AXES];
    logic signed [pirb_pkg::PROD_W-1:0] prod_reg  [pirb_pkg::AXES][pirb_pkg::AXES];
    logic signed [pirb_pkg::SUM_W-1:0]  sum_next [pirb_pkg::AXES];
    logic signed [pirb_pkg::SUM_W-1:0]  sum_reg  [pirb_pkg::AXES];
    logic [AW-1:0]                      mag_next [pirb_pkg::AXES];
    logic [AW-1:0]                      mag_reg  [pirb_pkg::AXES];
    logic [pirb_pkg::SIZE_W-1:0]        dist_next [pirb_pkg::AXES];
    logic [pirb_pkg::SIZE_W-1:0]        dist_reg  [pirb_pkg::AXES];
    logic [pirb_pkg::AXES-1:0]          in_box4_next;
    logic [pirb_pkg::AXES-1:0]          in_box4_reg;
    logic                               reject4_next;
    logic                               reject4_reg;
    logic [pirb_pkg::SQ_W-1:0]          sq_next [pirb_pkg::AXES];
    logic [pirb_pkg::SQ_W-1:0]          sq_reg  [pirb_pkg::AXES];
    logic [pirb_pkg::AXES-1:0]          in_box5_reg;
    logic                               reject5_reg;
    logic                               inside_next;
    logic                               inside_reg;

    // Handshake outputs
    assign cfg_ready     = 1'b1;
    assign s_axis_tready = stage_en[1];
    assign m_axis_tvalid = valid_reg[STAGES];
    assign m_axis_tdata  = {{(pirb_pkg::OUT_DATA_W - 1){1'b0}}, inside_reg};

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pirb_pkg::AXES; i++)
            begin
                half_size_reg[i] <= pirb_pkg::RESET_HALF_SIZE;
            end
            grow_radius_reg <= pirb_pkg::RESET_RADIUS;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (pirb_pkg::cfg_reg_t'(cfg_index))
                pirb_pkg::REG_HALF_SIZE_X: half_size_reg[0] <= cfg_data;
                pirb_pkg::REG_HALF_SIZE_Y: half_size_reg[1] <= cfg_data;
                pirb_pkg::REG_HALF_SIZE_Z: half_size_reg[2] <= cfg_data;
                pirb_pkg::REG_GROW_RADIUS: grow_radius_reg  <= cfg_data;
            endcase
        end
    end

    // Square the registered radius on every clock; it settles long before an item needs it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_sq_reg <= pirb_pkg::RESET_RADIUS_SQ;
        end
        else
        begin
            radius_sq_reg <= pirb_pkg::SQ_W'(grow_radius_reg) *
                             pirb_pkg::SQ_W'(grow_radius_reg);
        end
    end

    // Advance a stage when it is empty or its successor moves
    always_comb
    begin
        stage_en[STAGES] = !valid_reg[STAGES] || m_axis_tready;
        for (int k = STAGES - 1; k >= 1; k--)
        begin
            stage_en[k] = !valid_reg[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[1])
            begin
                valid_reg[1] <= s_axis_tvalid;
            end
            for (int k = 2; k <= STAGES; k++)
            begin
                if (stage_en[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Stage 1: unpack and form the nine products rot[j][i] * off[j]
    always_comb
    begin
        for (int j = 0; j < pirb_pkg::AXES; j++)
        begin
            off_in[j] = s_axis_tdata[j*pirb_pkg::OFF_W +: pirb_pkg::OFF_W];
            for (int c = 0; c < pirb_pkg::AXES; c++)
            begin
                rot_in[j][c] = s_axis_tdata[pirb_pkg::AXES*pirb_pkg::OFF_W +
                                            (j*pirb_pkg::AXES + c)*pirb_pkg::ROT_W
                                            +: pirb_pkg::ROT_W];
            end
        end
        for (int i = 0; i < pirb_pkg::AXES; i++)
        begin
            for (int j = 0; j < pirb_pkg::AXES; j++)
            begin
                prod_next[i][j] = $signed(rot_in[j][i]) * $signed(off_in[j]);
            end
        end
    end

    // Stage 2: sum products into box-frame coordinates
    always_comb
    begin
        for (int i = 0; i < pirb_pkg::AXES; i++)
        begin
            sum_next[i] = pirb_pkg::SUM_W'(prod_reg[i][0]) +
                          pirb_pkg::SUM_W'(prod_reg[i][1]) +
                          pirb_pkg::SUM_W'(prod_reg[i][2]);
        end
    end

    // Stage 3: take magnitude and drop the extra fraction bits
    always_comb
    begin
        logic [pirb_pkg::SUM_W-1:0] abs_val;
        abs_val = '0;
        for (int i = 0; i < pirb_pkg::AXES; i++)
        begin
            abs_val     = sum_reg[i][pirb_pkg::SUM_W-1] ? -sum_reg[i] : sum_reg[i];
            mag_next[i] = abs_val[pirb_pkg::MAG_W-1:FRAC_BITS];
        end
    end

    // Stage 4: reject far points, flag in-box axes, distance to the face
    always_comb
    begin
        logic [CW-1:0] a_ext;
        logic [CW-1:0] h_ext;
        logic [CW-1:0] lim;
        logic [CW-1:0] diff;
        a_ext        = '0;
        h_ext        = '0;
        lim          = '0;
        diff         = '0;
        reject4_next = 1'b0;
        for (int i = 0; i < pirb_pkg::AXES; i++)
        begin
            a_ext = CW'(mag_reg[i]);
            h_ext = CW'(half_size_reg[i]);
            lim   = h_ext + CW'(grow_radius_reg);
            in_box4_next[i] = (a_ext <= h_ext);
            diff  = in_box4_next[i] ? (h_ext - a_ext) : (a_ext - h_ext);
            // Inside the outer bound the distance fits the size width
            dist_next[i] = diff[pirb_pkg::SIZE_W-1:0];
            if (a_ext > lim)
            begin
                reject4_next = 1'b1;
            end
        end
    end

    // Stage 5: square the face distances
    always_comb
    begin
        for (int i = 0; i < pirb_pkg::AXES; i++)
        begin
            sq_next[i] = pirb_pkg::SQ_W'(dist_reg[i]) * pirb_pkg::SQ_W'(dist_reg[i]);
        end
    end

    // Stage 6: slab, edge cylinder and corner sphere tests
    always_comb
    begin
        logic [pirb_pkg::SQ_W:0]   sum01;
        logic [pirb_pkg::SQ_W:0]   sum12;
        logic [pirb_pkg::SQ_W:0]   sum20;
        logic [pirb_pkg::SQ_W+1:0] sum_all;
        logic [pirb_pkg::SQ_W+1:0] r2_ext;
        logic                      two_in;
        sum01   = (pirb_pkg::SQ_W+1)'(sq_reg[0]) + (pirb_pkg::SQ_W+1)'(sq_reg[1]);
        sum12   = (pirb_pkg::SQ_W+1)'(sq_reg[1]) + (pirb_pkg::SQ_W+1)'(sq_reg[2]);
        sum20   = (pirb_pkg::SQ_W+1)'(sq_reg[2]) + (pirb_pkg::SQ_W+1)'(sq_reg[0]);
        sum_all = (pirb_pkg::SQ_W+2)'(sum01) + (pirb_pkg::SQ_W+2)'(sq_reg[2]);
        r2_ext  = (pirb_pkg::SQ_W+2)'(radius_sq_reg);
        two_in  = (in_box5_reg[0] && in_box5_reg[1]) ||
                  (in_box5_reg[1] && in_box5_reg[2]) ||
                  (in_box5_reg[2] && in_box5_reg[0]);
        inside_next = !reject5_reg &&
                      (two_in ||
                       (in_box5_reg[0] && ((pirb_pkg::SQ_W+2)'(sum12) <= r2_ext)) ||
                       (in_box5_reg[1] && ((pirb_pkg::SQ_W+2)'(sum20) <= r2_ext)) ||
                       (in_box5_reg[2] && ((pirb_pkg::SQ_W+2)'(sum01) <= r2_ext)) ||
                       (sum_all <= r2_ext));
    end

    // Payload registers, each loaded with its stage enable
    always_ff @(posedge clk)
    begin
        if (stage_en[1])
        begin
            prod_reg <= prod_next;
        end
        if (stage_en[2])
        begin
            sum_reg <= sum_next;
        end
        if (stage_en[3])
        begin
            mag_reg <= mag_next;
        end
        if (stage_en[4])
        begin
            dist_reg    <= dist_next;
            in_box4_reg <= in_box4_next;
            reject4_reg <= reject4_next;
        end
        if (stage_en[5])
        begin
            sq_reg      <= sq_next;
            in_box5_reg <= in_box4_reg;
            reject5_reg <= reject4_reg;
        end
        if (stage_en[6])
        begin
            inside_reg <= inside_next;
        end
    end

    // A free output slot lets every stage move
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is ready");

    // The radius square follows a radius write by way of the radius register
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_valid && cfg_ready && cfg_index == pirb_pkg::REG_GROW_RADIUS) |=> ##1
        (radius_sq_reg == pirb_pkg::SQ_W'($past(cfg_data, 2)) *
                          pirb_pkg::SQ_W'($past(cfg_data, 2))))
        else $error("radius square out of step with radius write");

    // A point beyond the outer bound always yields outside
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[5] && stage_en[6] && reject5_reg) |=> (m_axis_tvalid && !inside_reg))
        else $error("rejected point reported inside");

    // A blocked magnitude stage keeps its item
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg[3] && !stage_en[3]) |=> (valid_reg[3] && $stable(mag_reg[0])))
        else $error("stalled stage lost its item");

endmodule

`default_nettype wire

>>> tb/tb_point_in_rounded_box_core.sv
`timescale 1ns / 1ps

module tb_point_in_rounded_box_core;

    localparam int     FRAC_BITS      = 16;
    localparam longint ONE            = longint'(1) << FRAC_BITS;
    localparam longint HALF_LSB       = ONE / 2;
    localparam longint OFF_MIN        = -(longint'(1) << (pirb_pkg::OFF_W - 1));
    localparam longint OFF_MAX        = (longint'(1) << (pirb_pkg::OFF_W - 1)) - 1;
    localparam longint POINT_LIM      = (longint'(1) << (pirb_pkg::OFF_W - 2)) - 1;
    localparam longint SIZE_TOP       = (longint'(1) << pirb_pkg::SIZE_W) - 1;
    localparam logic [pirb_pkg::SIZE_W-1:0] GEOM_RESET = 24'd32768;
    localparam int     PHASES         = 8;
    localparam int     RANDOM_PER_PHASE = 200;
    localparam int     SETTLE_CYCLES  = 12;

    // One input transaction, offset_x in the lowest bits
    typedef struct packed {
        logic [pirb_pkg::IN_DATA_W-3*pirb_pkg::OFF_W-9*pirb_pkg::ROT_W-1:0] fill;
        logic signed [pirb_pkg::ROT_W-1:0] rot_22;
        logic signed [pirb_pkg::ROT_W-1:0] rot_21;
        logic signed [pirb_pkg::ROT_W-1:0] rot_20;
        logic signed [pirb_pkg::ROT_W-1:0] rot_12;
        logic signed [pirb_pkg::ROT_W-1:0] rot_11;
        logic signed [pirb_pkg::ROT_W-1:0] rot_10;
        logic signed [pirb_pkg::ROT_W-1:0] rot_02;
        logic signed [pirb_pkg::ROT_W-1:0] rot_01;
        logic signed [pirb_pkg::ROT_W-1:0] rot_00;
        logic signed [pirb_pkg::OFF_W-1:0] off_z;
        logic signed [pirb_pkg::OFF_W-1:0] off_y;
        logic signed [pirb_pkg::OFF_W-1:0] off_x;
    } point_t;

    typedef longint rot_mat_t [3][3];

    logic                              clk           = 1'b0;
    logic                              rst_n         = 1'b0;
    logic                              s_axis_tvalid = 1'b0;
    logic                              s_axis_tready;
    logic [pirb_pkg::IN_DATA_W-1:0]    s_axis_tdata  = '0;
    logic                              m_axis_tvalid;
    logic                              m_axis_tready = 1'b0;
    logic [pirb_pkg::OUT_DATA_W-1:0]   m_axis_tdata;
    logic                              cfg_valid     = 1'b0;
    logic                              cfg_ready;
    pirb_pkg::cfg_reg_t                cfg_index     = pirb_pkg::REG_HALF_SIZE_X;
    logic [pirb_pkg::SIZE_W-1:0]       cfg_data      = '0;

    // Geometry as the block should hold it
    logic [pirb_pkg::SIZE_W-1:0] box_half [3] = '{GEOM_RESET, GEOM_RESET, GEOM_RESET};
    logic [pirb_pkg::SIZE_W-1:0] box_radius   = GEOM_RESET;

    point_t point_pending_q [$];
    logic   inside_expect_q [$];
    logic   point_taken  = 1'b0;
    int     tx_idle_pct  = 0;
    int     rx_stall_pct = 0;
    int     fail_count   = 0;

    point_in_rounded_box_core #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint pick(input longint lo, input longint hi);
        return lo + longint'($urandom_range(32'(hi - lo)));
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint isqrt(input longint v);
        longint s;
        s = longint'($sqrt(real'(v)));
        while (s * s > v)
            s--;
        while ((s + 1) * (s + 1) <= v)
            s++;
        return s;
    endfunction

    function automatic point_t make_point(input longint ox, input longint oy, input longint oz,
                                          input rot_mat_t m);
        point_t p;
        p        = '0;
        p.off_x  = ox[pirb_pkg::OFF_W-1:0];
        p.off_y  = oy[pirb_pkg::OFF_W-1:0];
        p.off_z  = oz[pirb_pkg::OFF_W-1:0];
        p.rot_00 = m[0][0][pirb_pkg::ROT_W-1:0];
        p.rot_01 = m[0][1][pirb_pkg::ROT_W-1:0];
        p.rot_02 = m[0][2][pirb_pkg::ROT_W-1:0];
        p.rot_10 = m[1][0][pirb_pkg::ROT_W-1:0];
        p.rot_11 = m[1][1][pirb_pkg::ROT_W-1:0];
        p.rot_12 = m[1][2][pirb_pkg::ROT_W-1:0];
        p.rot_20 = m[2][0][pirb_pkg::ROT_W-1:0];
        p.rot_21 = m[2][1][pirb_pkg::ROT_W-1:0];
        p.rot_22 = m[2][2][pirb_pkg::ROT_W-1:0];
        return p;
    endfunction

    // Expected inside flag for one point under the current geometry
    function automatic logic grown_box_hit(input point_t p);
        longint          off [3];
        longint          rot [3][3];
        longint          sum;
        longint unsigned a [3];
        longint unsigned h [3];
        longint unsigned gap_sq [3];
        longint unsigned gap;
        longint unsigned r;
        longint unsigned r_sq;
        logic            in_half [3];
        logic            hit;
        off[0]    = $signed(p.off_x);
        off[1]    = $signed(p.off_y);
        off[2]    = $signed(p.off_z);
        rot[0][0] = $signed(p.rot_00);
        rot[0][1] = $signed(p.rot_01);
        rot[0][2] = $signed(p.rot_02);
        rot[1][0] = $signed(p.rot_10);
        rot[1][1] = $signed(p.rot_11);
        rot[1][2] = $signed(p.rot_12);
        rot[2][0] = $signed(p.rot_20);
        rot[2][1] = $signed(p.rot_21);
        rot[2][2] = $signed(p.rot_22);
        r    = longint'(box_radius);
        r_sq = r * r;
        // rotate into the box frame with the transpose, truncate the magnitude
        for (int i = 0; i < 3; i++)
        begin
            sum        = rot[0][i] * off[0] + rot[1][i] * off[1] + rot[2][i] * off[2];
            a[i]       = ((sum < 0) ? -sum : sum) >> FRAC_BITS;
            h[i]       = longint'(box_half[i]);
            in_half[i] = (a[i] <= h[i]);
            gap        = (a[i] >= h[i]) ? (a[i] - h[i]) : (h[i] - a[i]);
            gap_sq[i]  = gap * gap;
        end
        hit = 1'b0;
        if (a[0] <= h[0] + r && a[1] <= h[1] + r && a[2] <= h[2] + r)
        begin
            if ((in_half[0] && in_half[1]) || (in_half[1] && in_half[2]) ||
                (in_half[2] && in_half[0]))
                hit = 1'b1;
            else if (in_half[0] && gap_sq[1] + gap_sq[2] <= r_sq)
                hit = 1'b1;
            else if (in_half[1] && gap_sq[2] + gap_sq[0] <= r_sq)
                hit = 1'b1;
            else if (in_half[2] && gap_sq[0] + gap_sq[1] <= r_sq)
                hit = 1'b1;
            else if (gap_sq[0] + gap_sq[1] + gap_sq[2] <= r_sq)
                hit = 1'b1;
        end
        return hit;
    endfunction

    // Signed permutation, optionally turned by angles with rational sine and cosine
    function automatic rot_mat_t random_rotation();
        rot_mat_t m;
        rot_mat_t q;
        rot_mat_t t;
        int       col [3];
        int       tmp;
        int       k;
        int       ax;
        int       u;
        int       v;
        longint   leg_a;
        longint   leg_b;
        longint   hyp;
        longint   cs;
        longint   sn;
        col = '{0, 1, 2};
        for (k = 2; k > 0; k--)
        begin
            tmp      = $urandom_range(k);
            u        = col[k];
            col[k]   = col[tmp];
            col[tmp] = u;
        end
        m = '{default: 0};
        for (k = 0; k < 3; k++)
            m[k][col[k]] = $urandom_range(1) ? ONE : -ONE;
        for (int turn = 0; turn < 2; turn++)
        begin
            if ($urandom_range(99) < 60)
            begin
                case ($urandom_range(4))
                    0:       begin leg_a = 3;  leg_b = 4;  hyp = 5;  end
                    1:       begin leg_a = 5;  leg_b = 12; hyp = 13; end
                    2:       begin leg_a = 8;  leg_b = 15; hyp = 17; end
                    3:       begin leg_a = 7;  leg_b = 24; hyp = 25; end
                    default: begin leg_a = 20; leg_b = 21; hyp = 29; end
                endcase
                cs = (leg_a * ONE + hyp / 2) / hyp;
                sn = (leg_b * ONE + hyp / 2) / hyp;
                if ($urandom_range(1))
                    sn = -sn;
                ax = $urandom_range(2);
                u  = (ax + 1) % 3;
                v  = (ax + 2) % 3;
                q  = '{default: 0};
                q[ax][ax] = ONE;
                q[u][u]   = cs;
                q[u][v]   = -sn;
                q[v][u]   = sn;
                q[v][v]   = cs;
                for (int i = 0; i < 3; i++)
                    for (int j = 0; j < 3; j++)
                        t[i][j] = clamp((m[i][0] * q[0][j] + m[i][1] * q[1][j] +
                                         m[i][2] * q[2][j] + HALF_LSB) >>> FRAC_BITS,
                                        -ONE, ONE);
                m = t;
            end
        end
        return m;
    endfunction

    // Point placed inside the box, near a face, edge cylinder, corner sphere or half size boundary, or spread around it
    function automatic point_t shaped_point();
        rot_mat_t m;
        longint   p [3];
        longint   hh [3];
        longint   off [3];
        longint   r;
        longint   g0;
        longint   g1;
        longint   rest;
        int       k;
        int       j;
        int       l;
        r = longint'(box_radius);
        for (int i = 0; i < 3; i++)
        begin
            hh[i] = longint'(box_half[i]);
            p[i]  = pick(0, hh[i]);
        end
        m = random_rotation();
        k = $urandom_range(2);
        j = (k + 1) % 3;
        l = (k + 2) % 3;
        case ($urandom_range(5))
            // outer face along one axis
            1: p[k] = hh[k] + r + pick(-4, 4);
            // cylinder around an edge parallel to axis k
            2:
            begin
                g0   = pick(0, r);
                p[j] = hh[j] + g0;
                p[l] = hh[l] + isqrt(r * r - g0 * g0) + pick(-3, 3);
            end
            // corner sphere
            3:
            begin
                g0   = pick(0, r);
                rest = r * r - g0 * g0;
                g1   = pick(0, isqrt(rest));
                p[k] = hh[k] + g0;
                p[j] = hh[j] + g1;
                p[l] = hh[l] + isqrt(rest - g1 * g1) + pick(-3, 3);
            end
            // half size boundary on two axes
            4:
            begin
                p[j] = hh[j] + pick(-3, 3);
                p[l] = hh[l] + pick(-3, 3) + ($urandom_range(1) ? pick(0, r) : 0);
            end
            5:
                for (int i = 0; i < 3; i++)
                    p[i] = pick(0, hh[i] + r + r / 4 + 4);
            default: ;
        endcase
        for (int i = 0; i < 3; i++)
        begin
            if ($urandom_range(1))
                p[i] = -p[i];
            p[i] = clamp(p[i], -POINT_LIM, POINT_LIM);
        end
        // map the box-frame point back to world offsets
        for (int i = 0; i < 3; i++)
            off[i] = clamp((m[i][0] * p[0] + m[i][1] * p[1] + m[i][2] * p[2] + HALF_LSB)
                           >>> FRAC_BITS, OFF_MIN, OFF_MAX);
        return make_point(off[0], off[1], off[2], m);
    endfunction

    // Arbitrary offsets and rotation entries across the legal ranges
    function automatic point_t noise_point();
        rot_mat_t m;
        longint   off [3];
        longint   span;
        logic     full;
        full = 1'($urandom_range(1));
        span = longint'(1) << pick(8, 22);
        for (int i = 0; i < 3; i++)
        begin
            off[i] = full ? pick(OFF_MIN, OFF_MAX) : pick(-span, span);
            for (int j = 0; j < 3; j++)
                case ($urandom_range(9))
                    0:       m[i][j] = -ONE;
                    1:       m[i][j] = ONE;
                    2:       m[i][j] = 0;
                    default: m[i][j] = pick(-ONE, ONE);
                endcase
        end
        return make_point(off[0], off[1], off[2], m);
    endfunction

    task automatic write_reg(input pirb_pkg::cfg_reg_t idx, input longint val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[pirb_pkg::SIZE_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            pirb_pkg::REG_HALF_SIZE_X: box_half[0] = val[pirb_pkg::SIZE_W-1:0];
            pirb_pkg::REG_HALF_SIZE_Y: box_half[1] = val[pirb_pkg::SIZE_W-1:0];
            pirb_pkg::REG_HALF_SIZE_Z: box_half[2] = val[pirb_pkg::SIZE_W-1:0];
            pirb_pkg::REG_GROW_RADIUS: box_radius  = val[pirb_pkg::SIZE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_geometry(input longint hx, input longint hy, input longint hz,
                                input longint rad);
        write_reg(pirb_pkg::REG_HALF_SIZE_X, hx);
        write_reg(pirb_pkg::REG_HALF_SIZE_Y, hy);
        write_reg(pirb_pkg::REG_HALF_SIZE_Z, hz);
        write_reg(pirb_pkg::REG_GROW_RADIUS, rad);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Hold until every point is sent and every result is back
    task automatic wait_drained();
        while (point_pending_q.size() != 0 || s_axis_tvalid || inside_expect_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Sender: advance to the next point once the current transaction is taken
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || point_taken))
        begin
            if (point_pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                s_axis_tdata  <= point_pending_q.pop_front();
                s_axis_tvalid <= 1'b1;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Predict the result of each accepted point
    always @(posedge clk)
    begin
        point_taken <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            inside_expect_q.push_back(grown_box_hit(point_t'(s_axis_tdata)));
    end

    // Receiver: stall at random
    always @(negedge clk)
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);

    // Compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin : result_check
        logic want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (inside_expect_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual inside_res %0d",
                         $time, m_axis_tdata[0]);
                fail_count++;
            end
            else
            begin
                want = inside_expect_q.pop_front();
                if (m_axis_tdata[0] !== want)
                begin
                    $display("%0t: inside_res mismatch, expected %0d, actual %0d",
                             $time, want, m_axis_tdata[0]);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin : stimulus
        rot_mat_t ident;
        rot_mat_t flip;
        rot_mat_t ones;
        rot_mat_t neg_ones;
        rot_mat_t nulls;
        rot_mat_t swap_xy;
        rot_mat_t half_x;
        ident    = '{'{ONE, 0, 0}, '{0, ONE, 0}, '{0, 0, ONE}};
        flip     = '{'{-ONE, 0, 0}, '{0, -ONE, 0}, '{0, 0, -ONE}};
        ones     = '{default: ONE};
        neg_ones = '{default: -ONE};
        nulls    = '{default: 0};
        swap_xy  = '{'{0, ONE, 0}, '{-ONE, 0, 0}, '{0, 0, ONE}};
        half_x   = '{'{ONE / 2, 0, 0}, '{0, ONE, 0}, '{0, 0, ONE}};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // sender idles lightly first, then the receiver does, then neither
            if (phase < 3)
            begin
                tx_idle_pct  = 10;
                rx_stall_pct = 76;
            end
            else if (phase < 6)
            begin
                tx_idle_pct  = 76;
                rx_stall_pct = 10;
            end
            else
            begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end

            case (phase)
                1: set_geometry(pick(4096, 262144), pick(4096, 262144), pick(4096, 262144),
                                pick(0, 131072));
                2: set_geometry(1, 1, 1, 0);
                3: set_geometry(1, 1, 1, SIZE_TOP);
                4: set_geometry(SIZE_TOP, SIZE_TOP, SIZE_TOP, SIZE_TOP);
                5: set_geometry(SIZE_TOP, SIZE_TOP, SIZE_TOP, 0);
                6: set_geometry(pick(1, 65536), 1, pick(65536, 1048576), pick(0, 1048576));
                7: set_geometry(pick(1024, 524288), pick(1024, 524288), pick(1024, 524288),
                                pick(0, 1048576));
                default: ;
            endcase

            // directed points against the reset geometry (half size and radius 0.5)
            if (phase == 0)
            begin
                point_pending_q.push_back(make_point(0, 0, 0, ident));
                // exactly on the outer face, then one step beyond
                point_pending_q.push_back(make_point(ONE, 0, 0, ident));
                point_pending_q.push_back(make_point(0, -ONE - 1, 0, ident));
                // just inside and just outside an edge cylinder
                point_pending_q.push_back(make_point(55938, 55938, 0, ident));
                point_pending_q.push_back(make_point(55939, -55939, 0, ident));
                // just inside and just outside a corner sphere
                point_pending_q.push_back(make_point(51686, 51686, 51686, ident));
                point_pending_q.push_back(make_point(-51687, 51687, -51687, ident));
                point_pending_q.push_back(make_point(32768, -32768, 32768, ident));
                // extreme offsets
                point_pending_q.push_back(make_point(OFF_MAX, OFF_MAX, OFF_MAX, ident));
                point_pending_q.push_back(make_point(OFF_MAX, OFF_MIN, OFF_MAX, nulls));
                point_pending_q.push_back(make_point(OFF_MIN, OFF_MIN, OFF_MIN, flip));
                // rotations that are not orthonormal
                point_pending_q.push_back(make_point(OFF_MIN, OFF_MIN, OFF_MIN, ones));
                point_pending_q.push_back(make_point(32768, -32768, 0, ones));
                point_pending_q.push_back(make_point(10000, 10000, 10000, neg_ones));
                point_pending_q.push_back(make_point(ONE, 0, 0, ones));
                // axis swap in the rotation
                point_pending_q.push_back(make_point(0, ONE, 0, swap_xy));
                point_pending_q.push_back(make_point(0, ONE + 1, 0, swap_xy));
                // truncation of the rotated magnitude
                point_pending_q.push_back(make_point(131073, 0, 0, half_x));
                point_pending_q.push_back(make_point(-131073, 0, 0, half_x));
                point_pending_q.push_back(make_point(131074, 0, 0, half_x));
                point_pending_q.push_back(make_point(0, 0, -ONE, flip));
            end

            repeat (RANDOM_PER_PHASE)
            begin
                if ($urandom_range(99) < 80)
                    point_pending_q.push_back(shaped_point());
                else
                    point_pending_q.push_back(noise_point());
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("point_in_rounded_box_core verification clean");
        else
            $display("point_in_rounded_box_core verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("point_in_rounded_box_core verification failed");
        $finish;
    end

endmodule

>>> files.f
hdl/pirb_pkg.sv
hdl/point_in_rounded_box_core.sv
tb/tb_point_in_rounded_box_core.sv
